// File: rtl/core/sed_pkg.sv
// Shared types and opcode constants for the script envelope detector.
// No dependencies; used by every module in rtl/core.
package sed_pkg;

    // Script opcodes the parser reacts to
    localparam logic [7:0] OP_ZERO      = 8'h00;
    localparam logic [7:0] OP_IF        = 8'h63;
    localparam logic [7:0] OP_IF_NOT    = 8'h64;
    localparam logic [7:0] OP_IF_END    = 8'h68;
    localparam logic [7:0] OP_PUSH_MAX  = 8'h4b;
    localparam logic [7:0] OP_LEN1      = 8'h4c;
    localparam logic [7:0] OP_LEN2      = 8'h4d;
    localparam logic [7:0] OP_LEN4      = 8'h4e;

    localparam int SKIP_WIDTH = 32;
    localparam int LEN_WIDTH  = 24;

    // Length bytes 00 63 seen after an outside PUSHDATA4
    localparam logic [LEN_WIDTH-1:0] LEN_ZERO_IF = 24'h006300;

    // One registered input byte
    typedef struct packed {
        logic [7:0] script_byte;
        logic       last_byte;
    } t_item;

    // Result handed from parser to the output buffer
    typedef struct packed {
        logic push;
        logic found;
    } t_result;

endpackage

// File: rtl/core/sed_in_reg.sv
// Input register stage for the script envelope detector.
// Depends on sed_pkg (t_item).
module sed_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sed_pkg::t_item i_item,
    output logic           o_valid,
    output sed_pkg::t_item o_item,
    input  logic           i_take
);

    logic           r_valid;
    sed_pkg::t_item r_item;

    // Holds one byte; refilled in the same cycle it is consumed
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: rtl/core/sed_parser.sv
// Byte parser: opcode decode, push skipping, nesting depth and found flag.
// Depends on sed_pkg (opcodes, t_item, t_result).
module sed_parser #(
    parameter int DEPTH_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  sed_pkg::t_item   i_item,
    input  logic             i_out_space,
    output logic             o_take,
    output sed_pkg::t_result o_result
);

    typedef enum logic [2:0] {
        MODE_OUT_OP   = 3'd0,
        MODE_OUT_ZERO = 3'd1,
        MODE_OUT_LEN  = 3'd2,
        MODE_IN_OP    = 3'd3,
        MODE_IN_LEN   = 3'd4
    } t_mode;

    t_mode                           r_mode, n_mode;
    logic [sed_pkg::SKIP_WIDTH-1:0]  r_skip, n_skip;
    logic [sed_pkg::LEN_WIDTH-1:0]   r_len, n_len;
    logic [1:0]                      r_cnt, n_cnt;
    logic [DEPTH_WIDTH-1:0]          r_depth, n_depth;
    logic                            r_found, n_found;

    logic [7:0]                      b;
    logic                            last;
    logic [sed_pkg::SKIP_WIDTH-1:0]  b_ext;
    logic [sed_pkg::SKIP_WIDTH-1:0]  len_asm;
    logic [DEPTH_WIDTH-1:0]          depth_dec;

    assign b     = i_item.script_byte;
    assign last  = i_item.last_byte;
    assign b_ext = {{(sed_pkg::SKIP_WIDTH-8){1'b0}}, b};

    // A last byte must find room in the output buffer; others always move on
    assign o_take = i_valid && (!last || i_out_space);

    always_comb begin
        case (r_cnt)
            2'd0:    len_asm = {8'h00, r_len} | {24'h0, b};
            2'd1:    len_asm = {8'h00, r_len} | {16'h0, b, 8'h00};
            2'd2:    len_asm = {8'h00, r_len} | {8'h00, b, 16'h0};
            default: len_asm = {8'h00, r_len} | {b, 24'h0};
        endcase
    end

    assign depth_dec = (r_depth != '0) ? r_depth - DEPTH_WIDTH'(1) : '0;

    always_comb begin
        n_mode  = r_mode;
        n_skip  = r_skip;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_depth = r_depth;
        n_found = r_found;

        if (!r_found) begin
            case (r_mode)
                MODE_OUT_ZERO, MODE_OUT_OP: begin
                    if (r_mode == MODE_OUT_ZERO && b == sed_pkg::OP_IF) begin
                        n_mode  = MODE_IN_OP;
                        n_depth = DEPTH_WIDTH'(1);
                    end else if (r_mode == MODE_OUT_OP && r_skip != '0) begin
                        n_skip = r_skip - 32'd1;
                    end else if (r_mode == MODE_OUT_ZERO || !last) begin
                        // outside opcode
                        n_mode = MODE_OUT_OP;
                        if (b == sed_pkg::OP_ZERO) begin
                            n_mode = MODE_OUT_ZERO;
                        end else if (b <= sed_pkg::OP_PUSH_MAX) begin
                            n_skip = b_ext;
                        end else if (b == sed_pkg::OP_LEN1 ||
                                     b == sed_pkg::OP_LEN2 ||
                                     b == sed_pkg::OP_LEN4) begin
                            n_mode = MODE_OUT_LEN;
                            n_len  = '0;
                            n_cnt  = 2'd0;
                            if (b == sed_pkg::OP_LEN1) begin
                                n_skip = 32'd1;
                            end else if (b == sed_pkg::OP_LEN2) begin
                                n_skip = 32'd2;
                            end else begin
                                n_skip = 32'd4;
                            end
                        end
                    end
                end
                MODE_IN_OP: begin
                    if (r_skip != '0) begin
                        n_skip = r_skip - 32'd1;
                    end else if (b == sed_pkg::OP_IF || b == sed_pkg::OP_IF_NOT) begin
                        if (r_depth != '1) begin
                            n_depth = r_depth + DEPTH_WIDTH'(1);
                        end
                    end else if (b == sed_pkg::OP_IF_END) begin
                        n_depth = depth_dec;
                        if (depth_dec == '0) begin
                            n_found = 1'b1;
                        end
                    end else if (b != sed_pkg::OP_ZERO && b <= sed_pkg::OP_PUSH_MAX) begin
                        n_skip = b_ext;
                    end else if (b == sed_pkg::OP_LEN1 ||
                                 b == sed_pkg::OP_LEN2 ||
                                 b == sed_pkg::OP_LEN4) begin
                        n_mode = MODE_IN_LEN;
                        n_len  = '0;
                        n_cnt  = 2'd0;
                        if (b == sed_pkg::OP_LEN1) begin
                            n_skip = 32'd1;
                        end else if (b == sed_pkg::OP_LEN2) begin
                            n_skip = 32'd2;
                        end else begin
                            n_skip = 32'd4;
                        end
                    end
                end
                MODE_OUT_LEN, MODE_IN_LEN: begin
                    if (r_skip <= 32'd1) begin
                        // length complete: skip the push body
                        n_skip = len_asm;
                        n_len  = '0;
                        n_cnt  = 2'd0;
                        n_mode = (r_mode == MODE_IN_LEN) ? MODE_IN_OP : MODE_OUT_OP;
                    end else begin
                        // element cut short after PUSHDATA4 00 63 68
                        if (r_mode == MODE_OUT_LEN && last && r_skip == 32'd2 &&
                            r_cnt == 2'd2 && r_len == sed_pkg::LEN_ZERO_IF &&
                            b == sed_pkg::OP_IF_END) begin
                            n_found = 1'b1;
                        end
                        n_len  = len_asm[sed_pkg::LEN_WIDTH-1:0];
                        n_cnt  = r_cnt + 2'd1;
                        n_skip = r_skip - 32'd1;
                    end
                end
                default: begin
                    // unused codes behave as outside, expecting opcode
                    n_mode = MODE_OUT_OP;
                    if (r_skip != '0) begin
                        n_skip = r_skip - 32'd1;
                    end
                end
            endcase
        end
    end

    assign o_result.push  = o_take && last;
    assign o_result.found = n_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && last)) begin
            r_mode  <= MODE_OUT_OP;
            r_skip  <= '0;
            r_len   <= '0;
            r_cnt   <= 2'd0;
            r_depth <= '0;
            r_found <= 1'b0;
        end else if (o_take) begin
            r_mode  <= n_mode;
            r_skip  <= n_skip;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_depth <= n_depth;
            r_found <= n_found;
        end
    end

endmodule

// File: rtl/core/sed_out_buf.sv
// Two-entry result buffer decoupling the parser from the output stream.
// Depends on sed_pkg (t_result).
module sed_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sed_pkg::t_result i_result,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_data
);

    logic [1:0] r_cnt;
    logic       r_d0;
    logic       r_d1;
    logic       pop;

    // Space is taken from the registered count only
    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = {7'b0, r_d0};
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_result.push && !pop) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (pop && !i_result.push) begin
            r_cnt <= r_cnt - 2'd1;
        end

        if (i_result.push && !pop) begin
            if (r_cnt == 2'd0) begin
                r_d0 <= i_result.found;
            end else begin
                r_d1 <= i_result.found;
            end
        end else if (pop && !i_result.push) begin
            r_d0 <= r_d1;
        end else if (pop && i_result.push) begin
            if (r_cnt == 2'd1) begin
                r_d0 <= i_result.found;
            end else begin
                r_d0 <= r_d1;
                r_d1 <= i_result.found;
            end
        end
    end

endmodule

// File: rtl/core/script_envelope_detector.sv
// Script envelope detector: one script byte per transfer, one result per element.
// An element's last byte is held in the input register, and its result then waits in the result buffer.
// Throughput: 1 byte per cycle unless a last byte waits for buffer room; parser state sits after the input register.
// A 2-entry result buffer lets bytes keep flowing while a result waits downstream.
// Reset (i_rst_n low, synchronous) clears parser state and empties both buffers.
module script_envelope_detector #(
    parameter int DEPTH_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input byte stream
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] script_byte
    input  logic       i_s_axis_tlast,   // last_byte of the element
    // result stream, one transfer per element
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [0] envelope_found, [7:1] zero
);

    sed_pkg::t_item   in_item;
    sed_pkg::t_item   reg_item;
    sed_pkg::t_result result;
    logic             reg_valid;
    logic             take;
    logic             out_space;

    assign in_item.script_byte = i_s_axis_tdata;
    assign in_item.last_byte   = i_s_axis_tlast;

    // Input register: one byte held for the parser
    sed_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_valid (reg_valid),
        .o_item  (reg_item),
        .i_take  (take)
    );

    // Parser: mode, skip count, length assembly, nesting depth
    sed_parser #(
        .DEPTH_WIDTH (DEPTH_WIDTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (reg_valid),
        .i_item      (reg_item),
        .i_out_space (out_space),
        .o_take      (take),
        .o_result    (result)
    );

    // Result buffer toward the master side
    sed_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .o_space  (out_space),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata)
    );

endmodule

// File: tb/script_envelope_checker.sv
// Checker for the script envelope detector: watches both stream channels,
// predicts each element's result and compares it with the result transfers.
// Depends on sed_pkg for the opcode constants.
module script_envelope_checker
    import sed_pkg::*;
#(
    parameter int DEPTH_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    input  logic       i_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] script_byte
    input  logic       i_s_axis_tlast,   // last_byte
    input  logic       i_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    input  logic [7:0] i_m_axis_tdata,   // [0] envelope_found, [7:1] zero
    output int         o_pending,
    output int         o_err_count
);

    typedef enum logic [2:0] {
        PM_OUT_OP   = 3'd0,
        PM_OUT_ZERO = 3'd1,
        PM_OUT_LEN  = 3'd2,
        PM_IN_OP    = 3'd3,
        PM_IN_LEN   = 3'd4
    } t_pmode;

    // Scanner state for the element in flight
    t_pmode                 pmode;
    logic [31:0]            skip_cnt;
    logic [LEN_WIDTH-1:0]   len_acc;
    logic [1:0]             len_idx;
    logic [DEPTH_WIDTH-1:0] depth;
    logic                   found;

    logic envelope_due[$];
    int   err_total = 0;
    logic want;

    function automatic void clear_scan();
        pmode    = PM_OUT_OP;
        skip_cnt = '0;
        len_acc  = '0;
        len_idx  = '0;
        depth    = '0;
        found    = 1'b0;
    endfunction

    function automatic void start_len(t_pmode m, logic [31:0] n);
        pmode    = m;
        skip_cnt = n;
        len_acc  = '0;
        len_idx  = '0;
    endfunction

    function automatic void opcode_outside(logic [7:0] b);
        pmode = PM_OUT_OP;
        if (b == OP_ZERO) pmode = PM_OUT_ZERO;
        else if (b <= OP_PUSH_MAX) skip_cnt = 32'(b);
        else if (b == OP_LEN1) start_len(PM_OUT_LEN, 32'd1);
        else if (b == OP_LEN2) start_len(PM_OUT_LEN, 32'd2);
        else if (b == OP_LEN4) start_len(PM_OUT_LEN, 32'd4);
    endfunction

    function automatic void opcode_inside(logic [7:0] b);
        if (b == OP_IF || b == OP_IF_NOT) begin
            if (depth != '1) depth = depth + 1'b1;   // saturates
        end else if (b == OP_IF_END) begin
            if (depth != '0) depth = depth - 1'b1;
            if (depth == '0) found = 1'b1;
        end else if (b != OP_ZERO && b <= OP_PUSH_MAX) begin
            skip_cnt = 32'(b);
        end else if (b == OP_LEN1) begin
            start_len(PM_IN_LEN, 32'd1);
        end else if (b == OP_LEN2) begin
            start_len(PM_IN_LEN, 32'd2);
        end else if (b == OP_LEN4) begin
            start_len(PM_IN_LEN, 32'd4);
        end
    endfunction

    // Little-endian length byte; the final one turns into the skip count
    function automatic void take_len_byte(logic [7:0] b, logic last, t_pmode back);
        logic [31:0] shifted;
        shifted = 32'(b) << (8 * len_idx);
        if (skip_cnt <= 32'd1) begin
            skip_cnt = {8'h00, len_acc} | shifted;
            len_acc  = '0;
            len_idx  = '0;
            pmode    = back;
            return;
        end
        // element cut short inside an outside PUSHDATA4 length of 00 63 68
        if (pmode == PM_OUT_LEN && last && skip_cnt == 32'd2 && len_idx == 2'd2 &&
            len_acc == LEN_ZERO_IF && b == OP_IF_END)
            found = 1'b1;
        len_acc  = len_acc | shifted[LEN_WIDTH-1:0];
        len_idx  = len_idx + 2'd1;
        skip_cnt = skip_cnt - 32'd1;
    endfunction

    function automatic void scan_byte(logic [7:0] b, logic last);
        if (!found) begin
            case (pmode)
                PM_OUT_ZERO: begin
                    if (b == OP_IF) begin
                        pmode = PM_IN_OP;
                        depth = DEPTH_WIDTH'(1);
                    end else begin
                        opcode_outside(b);
                    end
                end
                PM_OUT_LEN: take_len_byte(b, last, PM_OUT_OP);
                PM_IN_OP: begin
                    if (skip_cnt != 0) skip_cnt = skip_cnt - 32'd1;
                    else opcode_inside(b);
                end
                PM_IN_LEN: take_len_byte(b, last, PM_IN_OP);
                default: begin
                    pmode = PM_OUT_OP;
                    if (skip_cnt != 0) skip_cnt = skip_cnt - 32'd1;
                    else if (!last) opcode_outside(b);
                end
            endcase
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            envelope_due.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                scan_byte(i_s_axis_tdata, i_s_axis_tlast);
                if (i_s_axis_tlast) begin
                    envelope_due.push_back(found);
                    clear_scan();
                end
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (envelope_due.size() == 0) begin
                    $error("envelope_found: no result expected, got %0d", i_m_axis_tdata[0]);
                    err_total++;
                end else begin
                    want = envelope_due.pop_front();
                    if (i_m_axis_tdata[0] !== want) begin
                        $error("envelope_found: expected %0d, got %0d", want,
                               i_m_axis_tdata[0]);
                        err_total++;
                    end
                    if (i_m_axis_tdata[7:1] !== 7'd0) begin
                        $error("tdata padding: expected 0, got %0h", i_m_axis_tdata[7:1]);
                        err_total++;
                    end
                end
            end
        end
        o_pending   <= envelope_due.size();
        o_err_count <= err_total;
    end

endmodule

// File: tb/tb_script_envelope_detector.sv
// Top of the script envelope detector testbench: clock, reset, byte stimulus
// and result back-pressure; checking lives in script_envelope_checker.
// Depends on sed_pkg, script_envelope_detector and script_envelope_checker.
module tb_script_envelope_detector;
    import sed_pkg::*;

    localparam int          DEPTH_WIDTH  = 16;
    localparam int          RANDOM_BYTES = 1750;
    localparam int          HOLD_CYCLES  = 400;
    // about 1800 bytes; even the longest gaps on every byte stay far below this
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;  // [7:0] script_byte
    logic       s_tlast = 1'b0;   // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [0] envelope_found, [7:1] zero

    int          chk_pending;
    int          chk_errors;
    int unsigned cycle_count = 0;

    // script bytes waiting to be offered, element boundaries carried in last_byte
    t_item       script_q[$];
    int unsigned tx_burst = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    always #10 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    script_envelope_detector #(
        .DEPTH_WIDTH(DEPTH_WIDTH)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    script_envelope_checker #(
        .DEPTH_WIDTH(DEPTH_WIDTH)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .i_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tlast (s_tlast),
        .i_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .i_m_axis_tdata (m_tdata),
        .o_pending      (chk_pending),
        .o_err_count    (chk_errors)
    );

    // ---------------------------------------------------------------
    // Element builders: append bytes to script_q
    // ---------------------------------------------------------------
    function automatic void put(logic [7:0] b);
        t_item it;
        it.script_byte = b;
        it.last_byte   = 1'b0;
        script_q.push_back(it);
    endfunction

    function automatic void end_element();
        script_q[script_q.size() - 1].last_byte = 1'b1;
    endfunction

    function automatic void put_random(int unsigned n);
        repeat (n) put(8'($urandom_range(0, 255)));
    endfunction

    // any opcode that is neither a push nor IF/NOTIF/ENDIF
    function automatic void put_plain_op();
        logic [7:0] b;
        b = 8'($urandom_range(8'h4f, 8'hff));
        if (b == OP_IF || b == OP_IF_NOT || b == OP_IF_END) b = 8'h61;
        put(b);
    endfunction

    // one data push in any of its encodings, payload included
    function automatic void put_push();
        int unsigned r, n;
        r = $urandom_range(0, 99);
        n = $urandom_range(0, 6);
        if (r < 45) begin
            n = $urandom_range(1, 6);
            put(8'(n));
        end else if (r < 60) begin
            put(OP_LEN1);
            put(n[7:0]);
        end else if (r < 72) begin
            if ($urandom_range(0, 9) == 0) n = $urandom_range(256, 300);
            put(OP_LEN2);
            put(n[7:0]);
            put(n[15:8]);
        end else if (r < 86) begin
            put(OP_LEN4);
            put(n[7:0]);
            put(n[15:8]);
            put(n[23:16]);
            put(n[31:24]);
        end else if (r < 94) begin
            n = $urandom_range(8'h40, OP_PUSH_MAX);
            put(8'(n));
        end else begin
            // random 32-bit length: usually swallows the rest of the element
            put(OP_LEN4);
            put_random(4);
            n = 0;
        end
        put_random(n);
    endfunction

    function automatic void put_outside_piece();
        if ($urandom_range(0, 9) < 6) put_push();
        else put_plain_op();
    endfunction

    // zero + IF, random nested body, usually closed completely
    function automatic void build_envelope();
        int unsigned r, nest, closing;
        repeat ($urandom_range(0, 2)) put_outside_piece();
        put(OP_ZERO);
        put(OP_IF);
        nest = 1;
        repeat ($urandom_range(0, 8)) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                put(r[0] ? OP_IF : OP_IF_NOT);
                nest++;
            end else if (r < 45 && nest > 1) begin
                put(OP_IF_END);
                nest--;
            end else if (r < 75) begin
                put_push();
            end else if (r < 95) begin
                put_plain_op();
            end else begin
                put(OP_ZERO);
            end
        end
        closing = ($urandom_range(0, 6) == 0) ? $urandom_range(0, nest - 1) : nest;
        repeat (closing) put(OP_IF_END);
        if ($urandom_range(0, 3) == 0) put_random($urandom_range(1, 3));
        end_element();
    endfunction

    // element ending just after an outside PUSHDATA4, near 00 63 68 or on it
    function automatic void build_len_cut();
        if ($urandom_range(0, 1) == 0) put_outside_piece();
        put(OP_LEN4);
        put(($urandom_range(0, 3) != 0) ? OP_ZERO   : 8'($urandom_range(0, 255)));
        put(($urandom_range(0, 3) != 0) ? OP_IF     : 8'($urandom_range(0, 255)));
        put(($urandom_range(0, 3) != 0) ? OP_IF_END : 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0) put_random(1);
        end_element();
    endfunction

    function automatic void build_plain_script();
        repeat ($urandom_range(1, 5)) begin
            put_outside_piece();
            if ($urandom_range(0, 5) == 0) put(OP_ZERO);   // zero not followed by IF
        end
        end_element();
    endfunction

    function automatic logic [7:0] hot_byte();
        case ($urandom_range(0, 7))
            0: return OP_ZERO;
            1: return OP_IF;
            2: return OP_IF_NOT;
            3: return OP_IF_END;
            4: return OP_LEN1;
            5: return OP_LEN2;
            6: return OP_LEN4;
            default: return 8'($urandom_range(1, OP_PUSH_MAX));
        endcase
    endfunction

    function automatic void build_noise();
        repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(0, 1) == 0) put(hot_byte());
            else put_random(1);
        end
        end_element();
    endfunction

    function automatic void build_random_element();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) build_envelope();
        else if (r < 63) build_len_cut();
        else if (r < 80) build_plain_script();
        else build_noise();
    endfunction

    // ---------------------------------------------------------------
    // Idle gap choice: mostly short, a few long, with gap-free bursts
    // ---------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (tx_burst != 0) begin
            tx_burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            tx_burst = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------
    // Input channel driver
    // ---------------------------------------------------------------
    task automatic send_byte(input t_item it, input bit gapless);
        int unsigned gap;
        gap = gapless ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.script_byte;
        s_tlast  <= it.last_byte;
        // transfer happens on the edge where tready is seen high
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drive_bytes(input int unsigned count, input bit gapless);
        repeat (count) begin
            if (script_q.size() != 0) send_byte(script_q.pop_front(), gapless);
        end
    endtask

    // sender stays quiet until every result owed has come out
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (chk_pending != 0);
    endtask

    // ---------------------------------------------------------------
    // Result channel back-pressure; one long hold-off on request
    // ---------------------------------------------------------------
    initial begin : result_sink
        int unsigned run, gap, r;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_req && !hold_done) begin
                // long stall: result buffer fills, input must back up
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            m_tready <= 1'b1;
            run = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 8);
            repeat (run) @(posedge clk);
            r = $urandom_range(0, 99);
            if (r < 30) gap = 0;
            else if (r < 80) gap = $urandom_range(1, 3);
            else if (r < 96) gap = $urandom_range(4, 10);
            else gap = $urandom_range(20, 60);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus and verdict
    // ---------------------------------------------------------------
    initial begin : stimulus
        int unsigned third;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // minimal envelope closed on the last byte
        put(OP_ZERO); put(OP_IF); put(OP_IF_END); end_element();
        // lone zero as last byte: never an opcode outside
        put(OP_ZERO); end_element();
        // cut inside an outside PUSHDATA4 length reading 00 63 68
        put(OP_LEN4); put(OP_ZERO); put(OP_IF); put(OP_IF_END); end_element();
        // PUSHDATA1 skipped outside, then envelope, tail ignored after the find
        put(OP_LEN1); put(8'h01); put(8'hff);
        put(OP_ZERO); put(OP_IF); put(OP_IF_END); put(OP_LEN4); end_element();
        // PUSHDATA2 skipped inside, NOTIF nesting
        put(OP_ZERO); put(OP_IF); put(OP_IF_NOT); put(OP_LEN2); put(8'h01); put(8'h00);
        put(OP_IF_END); put(OP_IF_END); end_element();
        // push running past the end hides the closing ENDIF: open region
        put(OP_ZERO); put(OP_IF); put(8'h02); put(OP_IF_END); end_element();
        // incomplete PUSHDATA2 length
        put(OP_LEN2); put(8'h01); end_element();
        drive_bytes(script_q.size(), 1'b0);
        wait_results();

        // random part: first third, drain, then the rest under a long hold-off
        while (script_q.size() < RANDOM_BYTES) build_random_element();
        third = script_q.size() / 3;
        drive_bytes(third, 1'b0);
        wait_results();
        hold_req = 1'b1;
        drive_bytes(script_q.size(), 1'b0);

        wait_results();
        repeat (8) @(posedge clk);   // catch any stray result after the last one
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/sed_pkg.sv
rtl/core/sed_in_reg.sv
rtl/core/sed_parser.sv
rtl/core/sed_out_buf.sv
rtl/core/script_envelope_detector.sv
tb/script_envelope_checker.sv
tb/tb_script_envelope_detector.sv
